### design/pvtp_pkg.sv
// shared constants for the polygon vertex table with perimeter
// field widths, request codes and default parameter values; no dependencies
`default_nettype none
package pvtp_pkg;
    localparam int SLOT_COUNT_DEF = 16;
    localparam int COORD_BITS_DEF = 16;

    localparam int REQ_W    = 3;
    localparam int SLOT_W   = 8;
    localparam int PT_W     = 16;
    localparam int SIDES_W  = 5;
    localparam int PERIM_W  = 28;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 72;

    typedef logic [REQ_W-1:0] t_req;
    localparam t_req REQ_ADD    = 3'd0;
    localparam t_req REQ_GET    = 3'd1;
    localparam t_req REQ_SET    = 3'd2;
    localparam t_req REQ_REMOVE = 3'd3;
    localparam t_req REQ_COUNT  = 3'd4;
    localparam t_req REQ_PERIM  = 3'd5;

    localparam logic [PERIM_W-1:0] PERIM_MAX = {PERIM_W{1'b1}};
    localparam int COUNT_MAX = 31;
endpackage
`default_nettype wire

### design/polygon_vertex_table_perimeter.sv
// Polygon vertex table with perimeter.
// Input stream: one request word per handshake; tuser carries the request kind,
// tdata the slot index and the point. Output stream: one result word per request;
// tuser carries ok, tdata the read vertex, side count and perimeter.
// Set, remove, unknown requests and a failed get go straight to the output
// register; a get of a held slot first reads the ram (S_RD, S_CHK). Add and
// count walk every slot through S_RD, S_CHK and S_NEXT. Perimeter also walks
// every slot and runs one edge per valid vertex after the first, plus the
// closing edge, through the squaring and one-bit-per-cycle square-root unit.
// Coordinates sit in one ram with registered read data; valid marks sit in
// flip-flops. Only one request is in flight, so reads and writes never overlap.
// Reset (synchronous, active low) empties every slot at once and drops any
// pending result. A new request is taken while a finished result still waits
// in the output register; a stalled receiver holds the next result back in the
// sequencer and the block stops taking requests until it drains.
// Depends on pvtp_pkg and pvtp_ram.
`default_nettype none
module polygon_vertex_table_perimeter #(
    parameter int SLOT_COUNT = pvtp_pkg::SLOT_COUNT_DEF,
    parameter int COORD_BITS = pvtp_pkg::COORD_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // slot_index [7:0], point_x [23:8], point_y [39:24]
    input  wire logic [pvtp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // req_type [2:0]
    input  wire logic [pvtp_pkg::REQ_W-1:0]       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // vertex_x [15:0], vertex_y [31:16], side_count [36:32],
    // perimeter_hundredths [64:37], zero [71:65]
    output logic      [pvtp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // ok [0]
    output logic                                  m_axis_tuser
);
    import pvtp_pkg::*;

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CB = COORD_BITS;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int D2W = 2 * CB + 1;
    localparam int NW = 2 * CB + 16;
    localparam int SW = NW / 2;
    localparam int KW = $clog2(SW + 1);
    localparam int EW = SW + 1;
    localparam int AW = (EW > PERIM_W ? EW : PERIM_W) + 1;
    localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_NEXT = 4'd3;
    localparam logic [3:0] S_SQ   = 4'd4;
    localparam logic [3:0] S_SUM  = 4'd5;
    localparam logic [3:0] S_SCL  = 4'd6;
    localparam logic [3:0] S_ROOT = 4'd7;
    localparam logic [3:0] S_ACC  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]            r_state;
    logic [SLOT_COUNT-1:0] r_valid;
    t_req                  r_req;
    logic [IW-1:0]         r_idx, r_empty;
    logic signed [CB-1:0]  r_px, r_py;
    logic                  r_dup, r_have, r_found, r_closing;
    logic [CW-1:0]         r_cnt;
    logic signed [CB-1:0]  r_fx, r_fy, r_lx, r_ly, r_ax, r_ay, r_bx, r_by;
    logic [2*CB-1:0]       r_sqx, r_sqy;
    logic [D2W-1:0]        r_d2;
    logic [NW-1:0]         r_n;
    logic [SW:0]           r_rem;
    logic [SW-1:0]         r_root;
    logic [KW-1:0]         r_k;
    logic [PERIM_W-1:0]    r_sum;
    logic                  r_res_ok;
    logic [PT_W-1:0]       r_res_x, r_res_y;
    logic [SIDES_W-1:0]    r_res_sides;
    logic [PERIM_W-1:0]    r_res_per;
    logic                  r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;
    logic                  r_ook;

    // incoming fields
    logic [SLOT_W-1:0]    in_slot;
    logic signed [CB-1:0] in_px, in_py;
    logic                 in_range, accept;
    assign in_slot  = s_axis_tdata[SLOT_W-1:0];
    assign in_px    = CB'($signed(s_axis_tdata[SLOT_W +: PT_W]));
    assign in_py    = CB'($signed(s_axis_tdata[SLOT_W+PT_W +: PT_W]));
    assign in_range = 32'(in_slot) < SLOT_COUNT;
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;

    // coordinate ram: {y, x}
    logic                 ram_we, ram_re;
    logic [IW-1:0]        ram_waddr;
    logic [2*CB-1:0]      ram_wdata, ram_rdata;
    logic signed [CB-1:0] cur_x, cur_y;
    assign cur_x = $signed(ram_rdata[CB-1:0]);
    assign cur_y = $signed(ram_rdata[2*CB-1:CB]);

    pvtp_ram #(.WIDTH(2 * CB), .DEPTH(SLOT_COUNT)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_idx),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_empty;
        ram_wdata = {r_py, r_px};
        ram_re    = (r_state == S_RD);
        if (accept && s_axis_tuser == REQ_SET && in_range) begin
            ram_we    = 1'b1;
            ram_waddr = IW'(in_slot);
            ram_wdata = {in_py, in_px};
        end else if (r_state == S_NEXT && r_idx == LAST && r_req == REQ_ADD
                     && !r_dup && r_have) begin
            ram_we = 1'b1;
        end
    end

    // root step: bring down two bits, try {root, 01}
    logic [SW+2:0] rt_rem, rt_trial;
    logic          rt_ge;
    assign rt_rem   = {r_rem, r_n[NW-1:NW-2]};
    assign rt_trial = {1'b0, r_root, 2'b01};
    assign rt_ge    = rt_rem >= rt_trial;

    logic [EW-1:0] edge_len;
    logic [AW-1:0] acc_sum;
    assign edge_len = EW'(r_root) + EW'(r_rem > {1'b0, r_root});
    assign acc_sum  = AW'(r_sum) + AW'(edge_len);

    logic signed [CB:0] dx, dy;
    logic signed [2*CB+1:0] px2, py2;
    assign dx  = (CB+1)'(r_ax) - (CB+1)'(r_bx);
    assign dy  = (CB+1)'(r_ay) - (CB+1)'(r_by);
    assign px2 = dx * dx;
    assign py2 = dy * dy;

    logic [NW-1:0] d2n;
    assign d2n = NW'(r_d2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req       <= s_axis_tuser;
                        r_px        <= in_px;
                        r_py        <= in_py;
                        r_dup       <= 1'b0;
                        r_have      <= 1'b0;
                        r_found     <= 1'b0;
                        r_cnt       <= '0;
                        r_sum       <= '0;
                        r_res_x     <= '0;
                        r_res_y     <= '0;
                        r_res_sides <= '0;
                        r_res_per   <= '0;
                        case (s_axis_tuser)
                            REQ_ADD, REQ_COUNT, REQ_PERIM: begin
                                r_idx    <= '0;
                                r_res_ok <= 1'b0;
                                r_state  <= S_RD;
                            end
                            REQ_GET: begin
                                r_res_ok <= 1'b0;
                                if (in_range && r_valid[IW'(in_slot)]) begin
                                    r_idx   <= IW'(in_slot);
                                    r_state <= S_RD;
                                end else begin
                                    r_state <= S_OUT;
                                end
                            end
                            REQ_SET: begin
                                r_res_ok <= in_range;
                                r_state  <= S_OUT;
                                if (in_range) begin
                                    r_valid[IW'(in_slot)] <= 1'b1;
                                end
                            end
                            REQ_REMOVE: begin
                                r_res_ok <= in_range;
                                r_state  <= S_OUT;
                                if (in_range) begin
                                    r_valid[IW'(in_slot)] <= 1'b0;
                                end
                            end
                            default: begin
                                r_res_ok <= 1'b0;
                                r_state  <= S_OUT;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    case (r_req)
                        REQ_GET: begin
                            r_res_ok <= 1'b1;
                            r_res_x  <= PT_W'(cur_x);
                            r_res_y  <= PT_W'(cur_y);
                            r_state  <= S_OUT;
                        end
                        REQ_ADD: begin
                            r_state <= S_NEXT;
                            if (!r_valid[r_idx]) begin
                                r_empty <= r_idx;
                                r_have  <= 1'b1;
                            end else if (cur_x == r_px && cur_y == r_py) begin
                                r_dup <= 1'b1;
                            end
                        end
                        REQ_COUNT: begin
                            r_state <= S_NEXT;
                            if (r_valid[r_idx]) begin
                                r_cnt <= r_cnt + CW'(1);
                            end
                        end
                        REQ_PERIM: begin
                            if (r_valid[r_idx]) begin
                                r_lx <= cur_x;
                                r_ly <= cur_y;
                            end
                            if (r_valid[r_idx] && r_found) begin
                                r_ax      <= r_lx;
                                r_ay      <= r_ly;
                                r_bx      <= cur_x;
                                r_by      <= cur_y;
                                r_closing <= 1'b0;
                                r_state   <= S_SQ;
                            end else begin
                                r_state <= S_NEXT;
                                if (r_valid[r_idx]) begin
                                    r_found <= 1'b1;
                                    r_fx    <= cur_x;
                                    r_fy    <= cur_y;
                                end
                            end
                        end
                        default: begin
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_NEXT: begin
                    if (r_idx != LAST) begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_RD;
                    end else begin
                        case (r_req)
                            REQ_ADD: begin
                                r_state <= S_OUT;
                                if (!r_dup && r_have) begin
                                    r_valid[r_empty] <= 1'b1;
                                    r_res_ok <= 1'b1;
                                end
                            end
                            REQ_COUNT: begin
                                r_state  <= S_OUT;
                                r_res_ok <= 1'b1;
                                if (r_cnt == '0) begin
                                    r_res_sides <= '0;
                                end else if (32'(r_cnt) <= 2) begin
                                    r_res_sides <= SIDES_W'(1);
                                end else if (32'(r_cnt) > COUNT_MAX) begin
                                    r_res_sides <= SIDES_W'(COUNT_MAX);
                                end else begin
                                    r_res_sides <= SIDES_W'(r_cnt);
                                end
                            end
                            REQ_PERIM: begin
                                r_res_ok <= 1'b1;
                                if (r_found) begin
                                    r_ax      <= r_fx;
                                    r_ay      <= r_fy;
                                    r_bx      <= r_lx;
                                    r_by      <= r_ly;
                                    r_closing <= 1'b1;
                                    r_state   <= S_SQ;
                                end else begin
                                    r_state <= S_OUT;
                                end
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SQ: begin
                    r_sqx   <= px2[2*CB-1:0];
                    r_sqy   <= py2[2*CB-1:0];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_d2    <= D2W'(r_sqx) + D2W'(r_sqy);
                    r_state <= S_SCL;
                end
                S_SCL: begin
                    // times 10000 = 8192 + 1024 + 512 + 256 + 16
                    r_n     <= (d2n << 13) + (d2n << 10) + (d2n << 9) + (d2n << 8)
                               + (d2n << 4);
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_k     <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_n <= r_n << 2;
                    if (rt_ge) begin
                        r_rem  <= (SW+1)'(rt_rem - rt_trial);
                        r_root <= {r_root[SW-2:0], 1'b1};
                    end else begin
                        r_rem  <= rt_rem[SW:0];
                        r_root <= {r_root[SW-2:0], 1'b0};
                    end
                    r_k <= r_k + KW'(1);
                    if (r_k == KW'(SW - 1)) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (acc_sum > AW'(PERIM_MAX)) begin
                        r_sum <= PERIM_MAX;
                    end else begin
                        r_sum <= PERIM_W'(acc_sum);
                    end
                    if (r_closing) begin
                        r_res_per <= (acc_sum > AW'(PERIM_MAX)) ? PERIM_MAX
                                                                : PERIM_W'(acc_sum);
                        r_state   <= S_OUT;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
            r_ook   <= r_res_ok;
            r_odata <= {7'd0, r_res_per, r_res_sides, r_res_y, r_res_x};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ook;
endmodule
`default_nettype wire

### design/pvtp_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none
module pvtp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### design/pvtp_chk.sv
// port-level checker for polygon_vertex_table_perimeter, bound to the top level
// depends on pvtp_pkg for widths
`default_nettype none
module pvtp_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [pvtp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                            m_axis_tuser
);
    import pvtp_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word after reset");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("failed request with nonzero fields");

    a_no_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[36:32] != 5'd2)
        else $error("side count of two");

    a_per_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[64:37] != '0 |-> m_axis_tuser)
        else $error("perimeter without ok");
endmodule

bind polygon_vertex_table_perimeter pvtp_chk u_pvtp_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
`default_nettype wire
